// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is asserted
`define AST_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("assertion failed");

// clocked assertion that also holds across reset
`define AST_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/ids_pkg.sv =====
// types, codes and steering tables of the dock search controller
package ids_pkg;

    localparam int NUM_CFG = 8;
    localparam int CFG_W   = 16;
    localparam int CFG_AW  = 3;
    localparam int IN_W    = 64;
    localparam int OUT_W   = 24;

    // register indexes
    localparam logic [CFG_AW-1:0] REG_SONG_DEBOUNCE  = 3'd0;
    localparam logic [CFG_AW-1:0] REG_CHARGE_HOLD    = 3'd1;
    localparam logic [CFG_AW-1:0] REG_LEAVE_LED      = 3'd2;
    localparam logic [CFG_AW-1:0] REG_NO_SIGNAL      = 3'd3;
    localparam logic [CFG_AW-1:0] REG_SPIN_TIMEOUT   = 3'd4;
    localparam logic [CFG_AW-1:0] REG_TURN_MIN       = 3'd5;
    localparam logic [CFG_AW-1:0] REG_BACKOFF        = 3'd6;
    localparam logic [CFG_AW-1:0] REG_RETREAT_TOTAL  = 3'd7;

    localparam logic [CFG_W-1:0] RST_SONG_DEBOUNCE = 16'd1000;
    localparam logic [CFG_W-1:0] RST_CHARGE_HOLD   = 16'd1000;
    localparam logic [CFG_W-1:0] RST_LEAVE_LED     = 16'd500;
    localparam logic [CFG_W-1:0] RST_NO_SIGNAL     = 16'd10000;
    localparam logic [CFG_W-1:0] RST_SPIN_TIMEOUT  = 16'd3000;
    localparam logic [CFG_W-1:0] RST_TURN_MIN      = 16'd1000;
    localparam logic [CFG_W-1:0] RST_BACKOFF       = 16'd2000;
    localparam logic [CFG_W-1:0] RST_RETREAT_TOTAL = 16'd3000;

    // operations
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_STOP  = 2'd2;

    // search phases
    localparam logic [2:0] PH_SPIN_START = 3'd0;
    localparam logic [2:0] PH_SPIN       = 3'd1;
    localparam logic [2:0] PH_SPIN_STOP  = 3'd2;
    localparam logic [2:0] PH_TURN       = 3'd3;
    localparam logic [2:0] PH_APPROACH   = 3'd4;
    localparam logic [2:0] PH_RETREAT    = 3'd5;

    // why the spin ended
    localparam logic [1:0] STOP_TIMEOUT = 2'd0;
    localparam logic [1:0] STOP_FRONT   = 2'd1;
    localparam logic [1:0] STOP_CH3     = 2'd2;
    localparam logic [1:0] STOP_CH4     = 2'd3;

    // led requests
    localparam logic [1:0] LED_NONE     = 2'd0;
    localparam logic [1:0] LED_CHARGING = 2'd1;
    localparam logic [1:0] LED_DONE     = 2'd2;
    localparam logic [1:0] LED_WHITE    = 2'd3;

    localparam logic [2:0]  STEER_NONE   = 3'd7;
    localparam logic [12:0] HEADING_TOL  = 13'd100;
    localparam logic [12:0] QUARTER_TURN = 13'd900;
    localparam logic [12:0] FULL_TURN    = 13'd3600;
    localparam logic [31:0] TOUCH_NEVER  = 32'hFFFF_FFFF;

    typedef logic signed [8:0] t_speed;

    localparam t_speed SPD_ZERO    = 9'sd0;
    localparam t_speed SPD_SLOW    = 9'sd100;
    localparam t_speed SPD_FAST    = 9'sd220;
    localparam t_speed SPD_BACK    = -9'sd100;
    localparam t_speed SPD_BACK_F  = -9'sd220;
    localparam t_speed SPD_RETREAT = -9'sd200;

    typedef struct packed {
        t_speed left;
        t_speed right;
    } t_wheels;

    typedef struct packed {
        logic [CFG_W-1:0] song_debounce;
        logic [CFG_W-1:0] charge_hold;
        logic [CFG_W-1:0] leave_led;
        logic [CFG_W-1:0] no_signal;
        logic [CFG_W-1:0] spin_timeout;
        logic [CFG_W-1:0] turn_min;
        logic [CFG_W-1:0] backoff;
        logic [CFG_W-1:0] retreat_total;
    } t_cfg;

    // first member sits in the high bits, so operation lands at bit 0
    typedef struct packed {
        logic [11:0] heading;
        logic        collision;
        logic        charging;
        logic        on_pile;
        logic [11:0] ir_hits;
        logic [31:0] now_ms;
        logic [1:0]  operation;
    } t_item;

    typedef struct packed {
        logic   search_active;
        logic   start_edge_run;
        logic   play_song;
        logic [1:0] led_mode;
        t_speed right_speed;
        t_speed left_speed;
        logic   motor_write;
    } t_result;

    typedef struct packed {
        logic        running;
        logic [2:0]  phase;
        logic [1:0]  spin_stop_reason;
        logic [31:0] phase_start_time;
        logic [11:0] target_heading;
        logic        song_pending;
        logic [31:0] song_arm_time;
        logic [31:0] last_charging_time;
        logic [31:0] last_touch_time;
        logic [31:0] last_signal_time;
    } t_state;

    // steering class from the ir pattern, in priority order
    function automatic logic [2:0] steer_class(input logic [11:0] ir);
        logic l1, r1, l2, r2, both1, both2;
        logic [2:0] cls;
        l1 = ir[0];
        r1 = ir[2];
        l2 = ir[3];
        r2 = ir[5];
        both1 = l1 & r1;
        both2 = l2 & r2;
        if (both1 && both2)                     cls = 3'd0;
        else if (r1 && l2)                      cls = 3'd0;
        else if (both1 && l2)                   cls = 3'd0;
        else if (both2 && r1)                   cls = 3'd0;
        else if (l1 && l2 && !r1 && !r2)        cls = 3'd1;
        else if (r1 && r2 && !l1 && !l2)        cls = 3'd2;
        else if (!both1 && both2)               cls = 3'd3;
        else if (both1 && !both2)               cls = 3'd4;
        else if (ir[10] && (ir[9] || ir[11]))   cls = 3'd5;
        else if (ir[7] && (ir[6] || ir[8]))     cls = 3'd6;
        else if (!both1 && !both2)              cls = 3'd0;
        else                                    cls = STEER_NONE;
        return cls;
    endfunction

    function automatic t_wheels fwd_wheels(input logic [2:0] cls);
        t_wheels w;
        case (cls)
            3'd0:    w = '{SPD_SLOW, SPD_SLOW};
            3'd1:    w = '{SPD_FAST, SPD_SLOW};
            3'd2:    w = '{SPD_SLOW, SPD_FAST};
            3'd3:    w = '{SPD_SLOW, SPD_FAST};
            3'd4:    w = '{SPD_FAST, SPD_SLOW};
            3'd5:    w = '{SPD_SLOW, SPD_ZERO};
            3'd6:    w = '{SPD_ZERO, SPD_SLOW};
            default: w = '{SPD_ZERO, SPD_ZERO};
        endcase
        return w;
    endfunction

    function automatic t_wheels rev_wheels(input logic [2:0] cls);
        t_wheels w;
        case (cls)
            3'd0:    w = '{SPD_SLOW, SPD_SLOW};
            3'd1:    w = '{SPD_BACK, SPD_BACK_F};
            3'd2:    w = '{SPD_BACK_F, SPD_BACK};
            3'd3:    w = '{SPD_BACK_F, SPD_BACK};
            3'd4:    w = '{SPD_BACK, SPD_BACK_F};
            3'd5:    w = '{SPD_ZERO, SPD_BACK};
            3'd6:    w = '{SPD_BACK, SPD_ZERO};
            default: w = '{SPD_ZERO, SPD_ZERO};
        endcase
        return w;
    endfunction

endpackage

// ===== hw/rtl/ir_dock_search_controller_top.sv =====
// dock search controller: input register, tick logic, result register
//
// channel   dir  width   contents
// s_axis    in   64+2    tick word on tdata, operation on tuser
// m_axis    out  24      motor, led, song and search status word
// cfg       in   3+16    timing register writes
//
// one word per cycle sustained while m_axis is not stalled; a word waits in the input register
// and leaves through the result register.
// all tick work is one combinational pass from the input register, the
// search state updates as the word moves into the result register.
// i_rst_n is synchronous: it clears both valid flags, the search state and
// loads the default timings. a stalled result holds, and the input register
// still takes a new word while the result register drains.
module ir_dock_search_controller_top
    import ids_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    // now_ms, ir_hits, on_pile, charging, collision, heading, 5 zero bits
    input  logic [IN_W-1:0]   i_s_tdata,
    // operation
    input  logic [1:0]        i_s_tuser,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    // motor_write, left_speed, right_speed, led_mode, play_song, start_edge_run,
    // search_active
    output logic [OUT_W-1:0]  o_m_tdata,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]  i_cfg_wdata
);

    t_cfg    w_cfg;
    t_state  r_state;
    t_state  n_state;
    t_result w_result;
    t_item   r_in;
    logic    r_in_valid;
    logic    r_out_valid;
    t_result r_out;
    logic    w_take;
    logic    w_adv;

    ids_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    ids_core u_core (
        .i_item   (r_in),
        .i_state  (r_state),
        .i_cfg    (w_cfg),
        .o_state  (n_state),
        .o_result (w_result)
    );

    // a word moves on when the result register is free or being emptied
    assign w_adv      = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_adv;
    assign w_take     = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            r_in_valid <= w_take || (r_in_valid && !w_adv);
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in <= t_item'({i_s_tdata[$bits(t_item)-$bits(i_s_tuser)-1:0], i_s_tuser});
        end
        if (w_adv) begin
            r_out <= w_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;

endmodule

// ===== hw/rtl/ids_cfg_regs.sv =====
// timing registers of the dock search controller
module ids_cfg_regs
    import ids_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_SONG_DEBOUNCE: n_cfg.song_debounce = i_cfg_wdata;
                REG_CHARGE_HOLD:   n_cfg.charge_hold   = i_cfg_wdata;
                REG_LEAVE_LED:     n_cfg.leave_led     = i_cfg_wdata;
                REG_NO_SIGNAL:     n_cfg.no_signal     = i_cfg_wdata;
                REG_SPIN_TIMEOUT:  n_cfg.spin_timeout  = i_cfg_wdata;
                REG_TURN_MIN:      n_cfg.turn_min      = i_cfg_wdata;
                REG_BACKOFF:       n_cfg.backoff       = i_cfg_wdata;
                REG_RETREAT_TOTAL: n_cfg.retreat_total = i_cfg_wdata;
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{RST_SONG_DEBOUNCE, RST_CHARGE_HOLD, RST_LEAVE_LED, RST_NO_SIGNAL,
                       RST_SPIN_TIMEOUT, RST_TURN_MIN, RST_BACKOFF, RST_RETREAT_TOTAL};
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hw/rtl/ids_core.sv =====
// one control tick: next search state and the result word
module ids_core
    import ids_pkg::*;
(
    input  t_item   i_item,
    input  t_state  i_state,
    input  t_cfg    i_cfg,
    output t_state  o_state,
    output t_result o_result
);

    logic [31:0] w_now;
    logic [31:0] w_sig_time;
    logic [31:0] w_sig_age;
    logic [31:0] w_el;
    logic        w_hd_match;
    logic [12:0] w_hd_sum;
    logic [12:0] w_quarter;
    logic [2:0]  w_cls;
    t_wheels     w_fwd;
    t_wheels     w_rev;

    assign w_now      = i_item.now_ms;
    assign w_sig_time = (i_item.ir_hits != 12'd0) ? w_now : i_state.last_signal_time;
    assign w_sig_age  = w_now - w_sig_time;
    assign w_el       = w_now - i_state.phase_start_time;

    // plain difference, no wrap around the circle
    assign w_hd_match =
        ({1'b0, i_item.heading} <= {1'b0, i_state.target_heading} + HEADING_TOL) &&
        ({1'b0, i_state.target_heading} <= {1'b0, i_item.heading} + HEADING_TOL);

    // sum stays below twice a full turn, one subtract is enough
    assign w_hd_sum  = {1'b0, i_item.heading} + QUARTER_TURN;
    assign w_quarter = (w_hd_sum >= FULL_TURN) ? (w_hd_sum - FULL_TURN) : w_hd_sum;

    assign w_cls = steer_class(i_item.ir_hits);
    assign w_fwd = fwd_wheels(w_cls);
    assign w_rev = rev_wheels(w_cls);

    always_comb begin
        o_state  = i_state;
        o_result = '0;

        case (i_item.operation)
            OP_START: begin
                o_state.running          = 1'b1;
                o_state.phase            = PH_SPIN_START;
                o_state.last_signal_time = w_now;
            end
            OP_STOP: begin
                o_state.running = 1'b0;
                o_state.phase   = PH_SPIN_START;
            end
            OP_TICK: begin
                if (i_item.on_pile) begin
                    o_result.motor_write = 1'b1;
                    if (i_state.song_pending &&
                        (w_now - i_state.song_arm_time) >= {16'd0, i_cfg.song_debounce}) begin
                        o_result.play_song   = 1'b1;
                        o_state.song_pending = 1'b0;
                    end
                    if (i_item.charging) begin
                        o_result.led_mode          = LED_CHARGING;
                        o_state.last_charging_time = w_now;
                    end else if ((w_now - i_state.last_charging_time) >=
                                 {16'd0, i_cfg.charge_hold}) begin
                        o_result.led_mode = LED_DONE;
                    end
                    o_state.last_touch_time = w_now;
                end else begin
                    o_state.song_pending  = 1'b1;
                    o_state.song_arm_time = w_now;
                    if ((w_now - i_state.last_touch_time) >= {16'd0, i_cfg.leave_led}) begin
                        o_result.led_mode       = LED_WHITE;
                        o_state.last_touch_time = TOUCH_NEVER;
                    end
                end

                if (i_state.running) begin
                    o_state.last_signal_time = w_sig_time;
                    if (w_sig_age >= {16'd0, i_cfg.no_signal}) begin
                        o_state.running         = 1'b0;
                        o_state.phase           = PH_SPIN_START;
                        o_result.start_edge_run = 1'b1;
                    end else begin
                        case (i_state.phase)
                            PH_SPIN_START: begin
                                o_result.motor_write     = 1'b1;
                                o_result.left_speed      = SPD_BACK;
                                o_result.right_speed     = SPD_SLOW;
                                o_state.target_heading   = i_item.heading;
                                o_state.phase_start_time = w_now;
                                o_state.phase            = PH_SPIN;
                            end
                            PH_SPIN: begin
                                if (|i_item.ir_hits[5:0] || |i_item.ir_hits[8:6] ||
                                    |i_item.ir_hits[11:9] ||
                                    (w_el >= {16'd0, i_cfg.spin_timeout} && w_hd_match)) begin
                                    if (|i_item.ir_hits[5:0]) begin
                                        o_state.spin_stop_reason = STOP_FRONT;
                                    end else if (|i_item.ir_hits[8:6]) begin
                                        o_state.spin_stop_reason = STOP_CH3;
                                    end else if (|i_item.ir_hits[11:9]) begin
                                        o_state.spin_stop_reason = STOP_CH4;
                                    end else begin
                                        o_state.spin_stop_reason = STOP_TIMEOUT;
                                    end
                                    o_result.motor_write = 1'b1;
                                    o_result.left_speed  = SPD_ZERO;
                                    o_result.right_speed = SPD_ZERO;
                                    o_state.phase        = PH_SPIN_STOP;
                                end
                            end
                            PH_SPIN_STOP: begin
                                if (i_state.spin_stop_reason == STOP_CH3) begin
                                    o_result.motor_write     = 1'b1;
                                    o_result.left_speed      = SPD_BACK;
                                    o_result.right_speed     = SPD_SLOW;
                                    o_state.target_heading   = w_quarter[11:0];
                                    o_state.phase_start_time = w_now;
                                    o_state.phase            = PH_TURN;
                                end else begin
                                    o_state.phase = PH_APPROACH;
                                end
                            end
                            PH_TURN: begin
                                if (w_el >= {16'd0, i_cfg.turn_min} && w_hd_match) begin
                                    o_result.motor_write = 1'b1;
                                    o_result.left_speed  = SPD_ZERO;
                                    o_result.right_speed = SPD_ZERO;
                                    o_state.phase        = PH_APPROACH;
                                end
                            end
                            PH_APPROACH: begin
                                if (i_item.collision) begin
                                    o_result.motor_write     = 1'b1;
                                    o_result.left_speed      = SPD_BACK;
                                    o_result.right_speed     = SPD_BACK;
                                    o_state.phase_start_time = w_now;
                                    o_state.phase            = PH_RETREAT;
                                end else if (w_cls != STEER_NONE) begin
                                    o_result.motor_write = 1'b1;
                                    o_result.left_speed  = w_fwd.left;
                                    o_result.right_speed = w_fwd.right;
                                end
                            end
                            PH_RETREAT: begin
                                if (w_el <= {16'd0, i_cfg.backoff}) begin
                                    o_result.motor_write = 1'b1;
                                    o_result.left_speed  = SPD_RETREAT;
                                    o_result.right_speed = SPD_RETREAT;
                                end else begin
                                    if (w_cls != STEER_NONE) begin
                                        o_result.motor_write = 1'b1;
                                        o_result.left_speed  = w_rev.left;
                                        o_result.right_speed = w_rev.right;
                                    end
                                    if (w_el >= {16'd0, i_cfg.retreat_total}) begin
                                        o_state.phase = PH_APPROACH;
                                    end
                                end
                            end
                            default: begin
                                o_state.phase = i_state.phase;
                            end
                        endcase
                    end
                end
            end
            default: begin
                o_state = i_state;
            end
        endcase

        o_result.search_active = o_state.running;
    end

endmodule

// ===== hw/rtl/ids_checker.sv =====
// port checker for the dock search controller, bound to the top level
`include "assert_macros.svh"

module ids_checker
    import ids_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_m_tvalid,
    input logic              i_m_tready,
    input logic [OUT_W-1:0]  o_m_tdata
);

    t_result w_res;
    logic    w_speeds_zero;
    logic    w_stall;

    assign w_res         = o_m_tdata;
    assign w_speeds_zero = (w_res.left_speed == SPD_ZERO) && (w_res.right_speed == SPD_ZERO);
    assign w_stall       = o_m_tvalid && !i_m_tready;

    // wheel speeds only carry a value when a motor command goes out
    `AST_CLK(a_idle_speeds_zero, i_clk, i_rst_n, (o_m_tvalid && !w_res.motor_write) |-> w_speeds_zero)

    // giving up the search always leaves it stopped
    `AST_CLK(a_edge_run_stops, i_clk, i_rst_n, (o_m_tvalid && w_res.start_edge_run) |-> !w_res.search_active)

    // nothing comes out in the cycle after reset
    `AST_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_m_tvalid)

    // a stalled word holds
    `AST_CLK(a_out_hold, i_clk, i_rst_n, w_stall |=> (o_m_tvalid && $stable(o_m_tdata)))

endmodule

bind ir_dock_search_controller_top ids_checker u_ids_checker (.*);

// ===== tb/ids_search_checker.sv =====
// checker for the dock search controller: predicts every result word and compares it
module ids_search_checker
    import ids_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    input  logic              i_s_tready,
    input  logic [IN_W-1:0]   i_s_tdata,
    input  logic [1:0]        i_s_tuser,
    input  logic              i_m_tvalid,
    input  logic              i_m_tready,
    input  logic [OUT_W-1:0]  i_m_tdata,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    output int                o_bad_count,
    output int                o_words_due
);
    timeunit 1ns;
    timeprecision 1ps;

    // timing registers as the block should hold them
    logic [CFG_W-1:0] tmr [NUM_CFG];

    // search and pile bookkeeping
    logic        srch_on;
    logic [2:0]  srch_phase;
    logic [1:0]  spin_why;
    logic [31:0] phase_t0;
    logic [11:0] aim_hdg;
    logic        song_armed;
    logic [31:0] song_t0;
    logic [31:0] chg_seen_ms;
    logic [31:0] touch_ms;
    logic [31:0] beacon_ms;

    t_result due_results [$];
    t_result got_word;
    t_result want_word;
    t_item   in_word;
    int      n_bad = 0;
    int      n_due = 0;

    assign o_bad_count = n_bad;
    assign o_words_due = n_due;

    // elapsed time, wrapping modulo 2^32
    function automatic logic [31:0] age(input logic [31:0] now_ms, input logic [31:0] since_ms);
        return now_ms - since_ms;
    endfunction

    // plain difference, no wrap around the circle
    function automatic logic near_aim(input logic [11:0] hdg);
        int d;
        d = int'(hdg) - int'(aim_hdg);
        return (d <= int'(HEADING_TOL)) && (d >= -int'(HEADING_TOL));
    endfunction

    // ir pattern priority, -1 when nothing applies
    function automatic int ir_pattern_class(input logic [11:0] ir);
        logic c1l, c1r, c2l, c2r, pair1, pair2;
        c1l   = ir[0];
        c1r   = ir[2];
        c2l   = ir[3];
        c2r   = ir[5];
        pair1 = c1l && c1r;
        pair2 = c2l && c2r;
        if ((pair1 && pair2) || (c1r && c2l) || (pair1 && c2l) || (pair2 && c1r)) return 0;
        if (c1l && c2l && !c1r && !c2r) return 1;
        if (c1r && c2r && !c1l && !c2l) return 2;
        if (!pair1 && pair2) return 3;
        if (pair1 && !pair2) return 4;
        if (ir[10] && (ir[9] || ir[11])) return 5;
        if (ir[7] && (ir[6] || ir[8])) return 6;
        if (!pair1 && !pair2) return 0;
        return -1;
    endfunction

    function automatic t_wheels pattern_wheels(input int cls, input logic backing);
        t_wheels w;
        w.left  = SPD_ZERO;
        w.right = SPD_ZERO;
        case (cls)
            0: begin
                w.left  = SPD_SLOW;
                w.right = SPD_SLOW;
            end
            1, 4: begin
                w.left  = backing ? SPD_BACK : SPD_FAST;
                w.right = backing ? SPD_BACK_F : SPD_SLOW;
            end
            2, 3: begin
                w.left  = backing ? SPD_BACK_F : SPD_SLOW;
                w.right = backing ? SPD_BACK : SPD_FAST;
            end
            5: begin
                w.left  = backing ? SPD_ZERO : SPD_SLOW;
                w.right = backing ? SPD_BACK : SPD_ZERO;
            end
            6: begin
                w.left  = backing ? SPD_BACK : SPD_ZERO;
                w.right = backing ? SPD_ZERO : SPD_SLOW;
            end
            default: ;
        endcase
        return w;
    endfunction

    // a later motor command in the same tick replaces an earlier one
    function automatic void set_drive(inout t_result res, input t_speed l, input t_speed r);
        res.motor_write = 1'b1;
        res.left_speed  = l;
        res.right_speed = r;
    endfunction

    function automatic t_result dock_step(input t_item w);
        t_result     res;
        t_wheels     wh;
        logic [31:0] el;
        logic        stopped;
        int          cls;
        res = '0;
        if (w.operation == OP_START) begin
            srch_on    = 1'b1;
            srch_phase = PH_SPIN_START;
            beacon_ms  = w.now_ms;
        end else if (w.operation == OP_STOP) begin
            srch_on    = 1'b0;
            srch_phase = PH_SPIN_START;
        end else if (w.operation == OP_TICK) begin
            if (w.on_pile) begin
                set_drive(res, SPD_ZERO, SPD_ZERO);
                if (song_armed && age(w.now_ms, song_t0) >= tmr[REG_SONG_DEBOUNCE]) begin
                    res.play_song = 1'b1;
                    song_armed    = 1'b0;
                end
                if (w.charging) begin
                    res.led_mode = LED_CHARGING;
                    chg_seen_ms  = w.now_ms;
                end else if (age(w.now_ms, chg_seen_ms) >= tmr[REG_CHARGE_HOLD]) begin
                    res.led_mode = LED_DONE;
                end
                touch_ms = w.now_ms;
            end else begin
                song_armed = 1'b1;
                song_t0    = w.now_ms;
                if (age(w.now_ms, touch_ms) >= tmr[REG_LEAVE_LED]) begin
                    res.led_mode = LED_WHITE;
                    touch_ms     = TOUCH_NEVER;
                end
            end

            if (srch_on) begin
                if (w.ir_hits != '0) beacon_ms = w.now_ms;
                if (age(w.now_ms, beacon_ms) >= tmr[REG_NO_SIGNAL]) begin
                    srch_on            = 1'b0;
                    srch_phase         = PH_SPIN_START;
                    res.start_edge_run = 1'b1;
                end else begin
                    el = age(w.now_ms, phase_t0);
                    case (srch_phase)
                        PH_SPIN_START: begin
                            set_drive(res, SPD_BACK, SPD_SLOW);
                            aim_hdg    = w.heading;
                            phase_t0   = w.now_ms;
                            srch_phase = PH_SPIN;
                        end
                        PH_SPIN: begin
                            stopped = 1'b1;
                            if (|w.ir_hits[5:0]) spin_why = STOP_FRONT;
                            else if (|w.ir_hits[8:6]) spin_why = STOP_CH3;
                            else if (|w.ir_hits[11:9]) spin_why = STOP_CH4;
                            else if (el >= tmr[REG_SPIN_TIMEOUT] && near_aim(w.heading))
                                spin_why = STOP_TIMEOUT;
                            else stopped = 1'b0;
                            if (stopped) begin
                                set_drive(res, SPD_ZERO, SPD_ZERO);
                                srch_phase = PH_SPIN_STOP;
                            end
                        end
                        PH_SPIN_STOP: begin
                            if (spin_why == STOP_CH3) begin
                                set_drive(res, SPD_BACK, SPD_SLOW);
                                aim_hdg = 12'((int'(w.heading) + int'(QUARTER_TURN))
                                              % int'(FULL_TURN));
                                phase_t0   = w.now_ms;
                                srch_phase = PH_TURN;
                            end else begin
                                srch_phase = PH_APPROACH;
                            end
                        end
                        PH_TURN: begin
                            if (el >= tmr[REG_TURN_MIN] && near_aim(w.heading)) begin
                                set_drive(res, SPD_ZERO, SPD_ZERO);
                                srch_phase = PH_APPROACH;
                            end
                        end
                        PH_APPROACH: begin
                            if (w.collision) begin
                                set_drive(res, SPD_BACK, SPD_BACK);
                                phase_t0   = w.now_ms;
                                srch_phase = PH_RETREAT;
                            end else begin
                                cls = ir_pattern_class(w.ir_hits);
                                if (cls >= 0) begin
                                    wh = pattern_wheels(cls, 1'b0);
                                    set_drive(res, wh.left, wh.right);
                                end
                            end
                        end
                        PH_RETREAT: begin
                            if (el <= tmr[REG_BACKOFF]) begin
                                set_drive(res, SPD_RETREAT, SPD_RETREAT);
                            end else begin
                                cls = ir_pattern_class(w.ir_hits);
                                if (cls >= 0) begin
                                    wh = pattern_wheels(cls, 1'b1);
                                    set_drive(res, wh.left, wh.right);
                                end
                                if (el >= tmr[REG_RETREAT_TOTAL]) srch_phase = PH_APPROACH;
                            end
                        end
                        default: ;
                    endcase
                end
            end
        end
        res.search_active = srch_on;
        return res;
    endfunction

    task automatic compare_field(input string fld, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", fld, want, got);
            n_bad++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tmr[REG_SONG_DEBOUNCE] = RST_SONG_DEBOUNCE;
            tmr[REG_CHARGE_HOLD]   = RST_CHARGE_HOLD;
            tmr[REG_LEAVE_LED]     = RST_LEAVE_LED;
            tmr[REG_NO_SIGNAL]     = RST_NO_SIGNAL;
            tmr[REG_SPIN_TIMEOUT]  = RST_SPIN_TIMEOUT;
            tmr[REG_TURN_MIN]      = RST_TURN_MIN;
            tmr[REG_BACKOFF]       = RST_BACKOFF;
            tmr[REG_RETREAT_TOTAL] = RST_RETREAT_TOTAL;
            srch_on     = 1'b0;
            srch_phase  = PH_SPIN_START;
            spin_why    = STOP_TIMEOUT;
            phase_t0    = '0;
            aim_hdg     = '0;
            song_armed  = 1'b0;
            song_t0     = '0;
            chg_seen_ms = '0;
            touch_ms    = '0;
            beacon_ms   = '0;
            due_results.delete();
        end else begin
            if (i_cfg_we) tmr[i_cfg_addr] = i_cfg_wdata;
            // a result never leaves in the cycle its word is taken, so check results first
            if (i_m_tvalid && i_m_tready) begin
                got_word = i_m_tdata;
                if (due_results.size() == 0) begin
                    $error("result word %h arrived with nothing outstanding", i_m_tdata);
                    n_bad++;
                end else begin
                    want_word = due_results.pop_front();
                    compare_field("motor_write", want_word.motor_write, got_word.motor_write);
                    compare_field("left_speed", want_word.left_speed, got_word.left_speed);
                    compare_field("right_speed", want_word.right_speed, got_word.right_speed);
                    compare_field("led_mode", want_word.led_mode, got_word.led_mode);
                    compare_field("play_song", want_word.play_song, got_word.play_song);
                    compare_field("start_edge_run", want_word.start_edge_run,
                                  got_word.start_edge_run);
                    compare_field("search_active", want_word.search_active,
                                  got_word.search_active);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                in_word = t_item'({i_s_tdata[$bits(t_item)-$bits(i_s_tuser)-1:0], i_s_tuser});
                due_results.push_back(dock_step(in_word));
            end
        end
        n_due = due_results.size();
    end

endmodule

// ===== tb/tb_top.sv =====
// testbench top: stimulus, flow control and verdict for the dock search controller
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ids_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int RAND_WORDS  = 700;
    localparam int QUIET_TAIL  = 120;
    localparam int HOLD_CYCLES = 64;
    localparam int CYCLE_LIMIT = 300000;

    typedef enum {TM_DEFAULT, TM_ZERO, TM_MAX, TM_SHORT, TM_RANDOM} t_timing_set;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata = '0;
    logic [1:0]        s_tuser = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b1;
    logic [OUT_W-1:0]  m_tdata;
    logic              cfg_we = 1'b0;
    logic [CFG_AW-1:0] cfg_addr = '0;
    logic [CFG_W-1:0]  cfg_wdata = '0;
    int                bad_count;
    int                words_due;

    int          cycle_no = 0;
    int          words_sent = 0;
    logic [31:0] t_ms = '0;
    logic [11:0] hdg = '0;
    bit          idling = 1'b1;
    bit          hold_req = 1'b0;

    ir_dock_search_controller_top uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata)
    );

    ids_search_checker u_chk (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata),
        .o_bad_count (bad_count),
        .o_words_due (words_due)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_no <= cycle_no + 1;
        if (cycle_no >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // called at a falling edge; returns at the falling edge after the word is taken,
    // with tvalid still high so a following word can go out without a gap
    task automatic send_word(input logic [1:0] op, input logic [31:0] now_ms,
                             input logic [11:0] ir, input logic pile, input logic chg,
                             input logic coll, input logic [11:0] hd);
        t_item w;
        w.operation = op;
        w.now_ms    = now_ms;
        w.ir_hits   = ir;
        w.on_pile   = pile;
        w.charging  = chg;
        w.collision = coll;
        w.heading   = hd;
        if (idling && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        s_tdata  = IN_W'({w.heading, w.collision, w.charging, w.on_pile, w.ir_hits, w.now_ms});
        s_tuser  = w.operation;
        s_tvalid = 1'b1;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        words_sent++;
    endtask

    // stop offering and wait until every outstanding result is back
    task automatic drain();
        s_tvalid = 1'b0;
        while (words_due != 0) @(negedge clk);
    endtask

    task automatic write_timing(input logic [CFG_AW-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = val;
        @(negedge clk);
    endtask

    function automatic logic [CFG_W-1:0] pick_timing(input t_timing_set set,
                                                    input logic [CFG_W-1:0] dflt);
        case (set)
            TM_ZERO:   return '0;
            TM_MAX:    return '1;
            TM_SHORT:  return CFG_W'($urandom_range(0, int'(dflt) / 8));
            TM_RANDOM: return CFG_W'($urandom_range(0, 65535));
            default:   return dflt;
        endcase
    endfunction

    // silence in four of ten draws, else single hits, one channel, the front pair or anything
    function automatic logic [11:0] rand_ir();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return '0;
            4:          return 12'b1 << $urandom_range(0, 11);
            5:          return 12'($urandom_range(1, 7)) << (3 * $urandom_range(0, 3));
            6:          return {6'b0, 6'($urandom)};
            default:    return 12'($urandom);
        endcase
    endfunction

    // receiver: random stalls, one long hold-off on request, none in the tail
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req && !hold_done) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end else if (idling && $urandom_range(0, 4) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
            m_tready = 1'b1;
        end
    end

    initial begin
        int          ep;
        int          base;
        int          n_ticks;
        int          step_max;
        int          h;
        bit          docked;
        logic [1:0]  op;
        t_timing_set set;
        ep = 0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // pile handling with reset timings
        send_word(OP_TICK, 32'd0, '0, 1'b0, 1'b0, 1'b0, 12'd0);
        send_word(OP_TICK, 32'd100, '0, 1'b1, 1'b1, 1'b0, 12'd0);
        send_word(OP_TICK, 32'd1200, '0, 1'b1, 1'b0, 1'b0, 12'd0);
        send_word(OP_TICK, 32'd1300, '0, 1'b0, 1'b0, 1'b0, 12'd0);
        send_word(OP_TICK, 32'd2000, '0, 1'b0, 1'b0, 1'b0, 12'd0);
        // white again right away, measured from the all-ones touch time
        send_word(OP_TICK, 32'd2001, '0, 1'b0, 1'b0, 1'b0, 12'd0);
        send_word(OP_TICK, 32'd3400, '0, 1'b1, 1'b0, 1'b0, 12'd0);
        send_word(OP_UNUSED, 32'd3500, 12'hFFF, 1'b1, 1'b1, 1'b1, 12'd3599);
        // spin, stop on channel 3, quarter turn across the 3600 wrap, approach
        send_word(OP_START, 32'd3600, '0, 1'b0, 1'b0, 1'b0, 12'd0);
        send_word(OP_TICK, 32'd3601, '0, 1'b0, 1'b0, 1'b0, 12'd0);
        send_word(OP_TICK, 32'd3602, 12'h040, 1'b0, 1'b0, 1'b0, 12'd0);
        send_word(OP_TICK, 32'd3603, '0, 1'b0, 1'b0, 1'b0, 12'd3599);
        send_word(OP_TICK, 32'd4700, '0, 1'b0, 1'b0, 1'b0, 12'd899);
        send_word(OP_TICK, 32'd4701, 12'hFFF, 1'b0, 1'b0, 1'b0, 12'd899);
        send_word(OP_TICK, 32'd4702, 12'h009, 1'b0, 1'b0, 1'b0, 12'd899);
        // collision: straight back, then steered reverse, then back to approach
        send_word(OP_TICK, 32'd4703, 12'h009, 1'b0, 1'b0, 1'b1, 12'd899);
        send_word(OP_TICK, 32'd4800, 12'h004, 1'b0, 1'b0, 1'b0, 12'd899);
        send_word(OP_TICK, 32'd7000, 12'h024, 1'b0, 1'b0, 1'b0, 12'd899);
        send_word(OP_TICK, 32'd7800, 12'h600, 1'b0, 1'b0, 1'b0, 12'd899);
        send_word(OP_TICK, 32'd7801, 12'h0C0, 1'b0, 1'b0, 1'b0, 12'd899);
        // silence long enough to give up
        send_word(OP_TICK, 32'd17801, '0, 1'b0, 1'b0, 1'b0, 12'd899);
        // spin ends on a full turn with the heading exactly at the tolerance
        send_word(OP_START, 32'd17900, '0, 1'b0, 1'b0, 1'b0, 12'd1800);
        send_word(OP_TICK, 32'd17901, '0, 1'b0, 1'b0, 1'b0, 12'd1800);
        send_word(OP_TICK, 32'd21000, '0, 1'b0, 1'b0, 1'b0, 12'd1900);
        send_word(OP_TICK, 32'd21001, '0, 1'b0, 1'b0, 1'b0, 12'd1900);
        send_word(OP_STOP, 32'hFFFF_FFFF, 12'hFFF, 1'b1, 1'b1, 1'b1, 12'd3599);
        drain();

        t_ms = 32'hFFFF_F000;
        base = words_sent;
        while (words_sent - base < RAND_WORDS) begin
            if (words_sent - base >= RAND_WORDS - QUIET_TAIL) idling = 1'b0;
            if (ep % 5 == 0 && ep > 0) begin
                drain();
                case ((ep / 5) % 5)
                    1:       set = TM_SHORT;
                    2:       set = TM_ZERO;
                    3:       set = TM_MAX;
                    4:       set = TM_RANDOM;
                    default: set = TM_SHORT;
                endcase
                if (ep == 30) set = TM_DEFAULT;
                write_timing(REG_SONG_DEBOUNCE, pick_timing(set, RST_SONG_DEBOUNCE));
                write_timing(REG_CHARGE_HOLD, pick_timing(set, RST_CHARGE_HOLD));
                write_timing(REG_LEAVE_LED, pick_timing(set, RST_LEAVE_LED));
                write_timing(REG_NO_SIGNAL, pick_timing(set, RST_NO_SIGNAL));
                write_timing(REG_SPIN_TIMEOUT, pick_timing(set, RST_SPIN_TIMEOUT));
                write_timing(REG_TURN_MIN, pick_timing(set, RST_TURN_MIN));
                write_timing(REG_BACKOFF, pick_timing(set, RST_BACKOFF));
                write_timing(REG_RETREAT_TOTAL, pick_timing(set, RST_RETREAT_TOTAL));
                cfg_we = 1'b0;
            end
            // the receiver goes quiet while words keep coming, so the block backs up
            if (ep == 3) hold_req = 1'b1;

            n_ticks = $urandom_range(10, 40);
            case ($urandom_range(0, 3))
                0:       step_max = 5;
                1:       step_max = 60;
                2:       step_max = 600;
                default: step_max = 4000;
            endcase
            docked = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 5) == 0) t_ms = $urandom;
            if ($urandom_range(0, 4) != 0)
                send_word(OP_START, t_ms, rand_ir(), 1'($urandom), 1'($urandom), 1'($urandom),
                          hdg);
            repeat (n_ticks) begin
                t_ms = t_ms + $urandom_range(1, step_max);
                h = int'(hdg) + int'($urandom_range(0, 120)) - 60;
                if ($urandom_range(0, 15) == 0) h = $urandom_range(0, 3599);
                if (h < 0) h = h + 3600;
                if (h >= 3600) h = h - 3600;
                hdg = 12'(h);
                case ($urandom_range(0, 39))
                    0:       op = OP_STOP;
                    1:       op = OP_START;
                    2:       op = OP_UNUSED;
                    default: op = OP_TICK;
                endcase
                send_word(op, t_ms, rand_ir(),
                          docked ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 19) == 0),
                          1'($urandom), ($urandom_range(0, 9) == 0), hdg);
            end
            ep++;
        end

        drain();
        repeat (8) @(posedge clk);
        if (bad_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
